// ===== hdl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WAV byte stream to DAC code block.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int HEADER_BYTES = 44;
  localparam int DAC_BITS     = 12;
  localparam int HPOS_W       = 6;
  localparam int PROD_W       = 16;   // widest sample times ten
  localparam int STEP_W       = 4;    // counts PROD_W divider steps

  localparam logic [DAC_BITS-1:0] DAC_MAX = {DAC_BITS{1'b1}};
  localparam logic [7:0] SIGN_FLIP = 8'h80;
  localparam logic [3:0] UNITY_GAIN = 4'd10;
  localparam logic [7:0] VOLUME_RESET = 8'd10;

  // result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // header status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_RIFF = 3'd1;
  localparam logic [2:0] ST_BAD_WAVE = 3'd2;
  localparam logic [2:0] ST_BAD_FMT  = 3'd3;
  localparam logic [2:0] ST_BAD_DATA = 3'd4;

  // one queued job for the back end
  typedef struct packed {
    logic                kind;
    logic [DAC_BITS-1:0] raw;
    logic [2:0]          status;
    logic [31:0]         rate;
    logic [15:0]         channels;
    logic [15:0]         bits;
    logic [31:0]         length;
  } wsd_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
    logic [7:0] expect_byte;
  } wsd_tag_t;

  // expected tag byte at a header offset
  function automatic wsd_tag_t tag_lookup(input logic [HPOS_W-1:0] p);
    wsd_tag_t t;
    t.hit = 1'b1;
    t.code = ST_OK;
    t.expect_byte = 8'h00;
    case (p)
      6'd0:  begin t.code = ST_BAD_RIFF; t.expect_byte = 8'h52; end // R
      6'd1:  begin t.code = ST_BAD_RIFF; t.expect_byte = 8'h49; end // I
      6'd2:  begin t.code = ST_BAD_RIFF; t.expect_byte = 8'h46; end // F
      6'd3:  begin t.code = ST_BAD_RIFF; t.expect_byte = 8'h46; end // F
      6'd8:  begin t.code = ST_BAD_WAVE; t.expect_byte = 8'h57; end // W
      6'd9:  begin t.code = ST_BAD_WAVE; t.expect_byte = 8'h41; end // A
      6'd10: begin t.code = ST_BAD_WAVE; t.expect_byte = 8'h56; end // V
      6'd11: begin t.code = ST_BAD_WAVE; t.expect_byte = 8'h45; end // E
      6'd12: begin t.code = ST_BAD_FMT;  t.expect_byte = 8'h66; end // f
      6'd13: begin t.code = ST_BAD_FMT;  t.expect_byte = 8'h6d; end // m
      6'd14: begin t.code = ST_BAD_FMT;  t.expect_byte = 8'h74; end // t
      6'd15: begin t.code = ST_BAD_FMT;  t.expect_byte = 8'h20; end // space
      6'd36: begin t.code = ST_BAD_DATA; t.expect_byte = 8'h64; end // d
      6'd37: begin t.code = ST_BAD_DATA; t.expect_byte = 8'h61; end // a
      6'd38: begin t.code = ST_BAD_DATA; t.expect_byte = 8'h74; end // t
      6'd39: begin t.code = ST_BAD_DATA; t.expect_byte = 8'h61; end // a
      default: t.hit = 1'b0;
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/wsd_front.sv =====
// ----------------------------------------------------------------------------
// wsd_front
// Byte parser: walks the header, checks tags, captures fields, and turns
// data bytes into raw sample jobs for the back end.
// ----------------------------------------------------------------------------
module wsd_front import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       file_start,
  output logic       job_valid,
  output wsd_cmd_t   job
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_IDLE   = 2'd2;

  logic [1:0]        phase, phase_next;
  logic [HPOS_W-1:0] hpos, hpos_next;
  logic [31:0]       dpos, dpos_next;
  logic [7:0]        low_hold, low_hold_next;
  logic [31:0]       rate, rate_next;
  logic [15:0]       chans, chans_next;
  logic [15:0]       bits, bits_next;
  logic [31:0]       length, length_next;
  logic [2:0]        tag_err, tag_err_next;
  wsd_tag_t          tag;
  logic [15:0]       word;

  assign word = {data_byte ^ SIGN_FLIP, low_hold};

  always_comb begin
    phase_next    = phase;
    hpos_next     = hpos;
    dpos_next     = dpos;
    low_hold_next = low_hold;
    rate_next     = rate;
    chans_next    = chans;
    bits_next     = bits;
    length_next   = length;
    tag_err_next  = tag_err;
    job_valid     = 1'b0;
    job           = '0;
    tag           = tag_lookup(hpos);

    // restart the file on the marked byte
    if (file_start) begin
      phase_next    = PH_HEADER;
      hpos_next     = '0;
      dpos_next     = '0;
      low_hold_next = '0;
      rate_next     = '0;
      chans_next    = '0;
      bits_next     = '0;
      length_next   = '0;
      tag_err_next  = ST_OK;
      tag           = tag_lookup('0);
    end

    case (phase_next)
      PH_HEADER: begin
        if (tag.hit && tag_err_next == ST_OK && data_byte != tag.expect_byte) begin
          tag_err_next = tag.code;
        end
        case (hpos_next) inside
          [6'd22:6'd23]: chans_next[8*hpos_next[0] +: 8] = data_byte;
          [6'd24:6'd27]: rate_next[8*hpos_next[1:0] +: 8] = data_byte;
          [6'd34:6'd35]: bits_next[8*hpos_next[0] +: 8] = data_byte;
          [6'd40:6'd43]: length_next[8*hpos_next[1:0] +: 8] = data_byte;
          default: ;
        endcase
        if (hpos_next == HPOS_W'(HEADER_BYTES - 1)) begin
          job_valid  = 1'b1;
          job.kind   = KIND_HEADER;
          job.status = tag_err_next;
          hpos_next  = '0;
          if (tag_err_next == ST_OK) begin
            job.rate     = rate_next;
            job.channels = chans_next;
            job.bits     = bits_next;
            job.length   = length_next;
            phase_next   = PH_DATA;
          end else begin
            phase_next = PH_IDLE;
          end
        end else begin
          hpos_next = hpos_next + 1'b1;
        end
      end
      PH_DATA: begin
        if (dpos_next >= length_next) begin
          phase_next = PH_IDLE;
        end else begin
          dpos_next = dpos_next + 1'b1;
          if (bits_next == 16'd8) begin
            job_valid = 1'b1;
            job.kind  = KIND_SAMPLE;
            job.raw   = DAC_BITS'(data_byte);
          end else if (bits_next == 16'd16) begin
            if (!dpos[0] || file_start) begin
              low_hold_next = data_byte;
            end else begin
              job_valid = 1'b1;
              job.kind  = KIND_SAMPLE;
              job.raw   = word[15 -: DAC_BITS];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      hpos     <= '0;
      dpos     <= '0;
      low_hold <= '0;
      rate     <= '0;
      chans    <= '0;
      bits     <= '0;
      length   <= '0;
      tag_err  <= ST_OK;
    end else if (in_fire) begin
      phase    <= phase_next;
      hpos     <= hpos_next;
      dpos     <= dpos_next;
      low_hold <= low_hold_next;
      rate     <= rate_next;
      chans    <= chans_next;
      bits     <= bits_next;
      length   <= length_next;
      tag_err  <= tag_err_next;
    end
  end

endmodule

// ===== hdl/wsd_jobq.sv =====
// ----------------------------------------------------------------------------
// wsd_jobq
// Two-entry job queue between the parser and the scaler.
// ----------------------------------------------------------------------------
module wsd_jobq import wsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr,
  input  wsd_cmd_t wr_job,
  output logic     q_full,
  input  logic     rd,
  output wsd_cmd_t rd_job,
  output logic     q_empty
);

  wsd_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = count == 2'd2;
  assign q_empty = count == 2'd0;
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== hdl/wsd_back.sv =====
// ----------------------------------------------------------------------------
// wsd_back
// Scaler: takes jobs from the queue, runs raw*10/volume through a bit-serial
// divider, saturates, and holds the finished item in the output register.
// ----------------------------------------------------------------------------
module wsd_back import wsd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [7:0]          volume_divisor,
  input  logic                q_empty,
  input  wsd_cmd_t            q_job,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic                result_kind,
  output logic [DAC_BITS-1:0] dac_code,
  output logic [2:0]          header_status,
  output logic [31:0]         sample_rate,
  output logic [15:0]         channel_count,
  output logic [15:0]         sample_bits,
  output logic [31:0]         data_length
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]          state;
  logic [7:0]          volume;
  wsd_cmd_t            work;
  logic [PROD_W-1:0]   dvd;
  logic [PROD_W-1:0]   quo;
  logic [7:0]          rem;
  logic [STEP_W-1:0]   step;
  logic                out_valid;
  logic                out_free;
  logic [8:0]          rem_sh;
  logic [8:0]          rem_diff;
  logic                ge;
  logic [PROD_W-1:0]   prod;
  logic [DAC_BITS-1:0] code_sat;

  assign empty    = ~out_valid;
  assign out_free = ~out_valid | pop;
  assign q_pop    = (state == B_IDLE) && !q_empty;

  // raw*10 as shift and add
  assign prod = {1'b0, q_job.raw, 3'b000} + {3'b000, q_job.raw, 1'b0};

  assign rem_sh   = {rem, dvd[PROD_W-1]};
  assign rem_diff = rem_sh - {1'b0, volume};
  assign ge       = rem_sh >= {1'b0, volume};

  // a zero divisor yields an all-ones quotient, which saturates below
  assign code_sat = (quo > PROD_W'(DAC_MAX)) ? DAC_MAX : quo[DAC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= VOLUME_RESET;
    end else if (cfg_write) begin
      volume <= volume_divisor;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          work <= q_job;
          dvd  <= prod;
          rem  <= '0;
          quo  <= '0;
          step <= '0;
        end
      end
      B_DIV: begin
        rem  <= ge ? rem_diff[7:0] : rem_sh[7:0];
        quo  <= {quo[PROD_W-2:0], ge};
        dvd  <= dvd << 1;
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state <= (q_job.kind == KIND_SAMPLE) ? B_DIV : B_DONE;
          end
        end
        B_DIV: begin
          if (step == STEP_W'(PROD_W - 1)) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_DONE && out_free) begin
      result_kind   <= work.kind;
      dac_code      <= (work.kind == KIND_SAMPLE) ? code_sat : '0;
      header_status <= work.status;
      sample_rate   <= work.rate;
      channel_count <= work.channels;
      sample_bits   <= work.bits;
      data_length   <= work.length;
    end
  end

endmodule

// ===== hdl/wav_stream_to_dac_core.sv =====
// ----------------------------------------------------------------------------
// wav_stream_to_dac_core
// WAV file byte stream in, header reports and 12-bit DAC codes out.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  input     push / full         data_byte, file_start
//  result    empty / pop         result_kind, dac_code, header_status,
//                                sample_rate, channel_count, sample_bits,
//                                data_length
//  config    cfg_write           volume_divisor
//
//  The parser takes one byte per cycle while the job queue has room.
//  A sample passes through the bit-serial divider in the scaler, while a
//  header report skips it. The divider sets the sustained rate.
//  Reset (rst, synchronous) restores volume 10 and the header phase.
//  A full result register stalls the scaler, and a full queue raises full.
// ----------------------------------------------------------------------------
module wav_stream_to_dac_core import wsd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte,
  input  logic                file_start,
  output logic                empty,
  input  logic                pop,
  output logic                result_kind,
  output logic [DAC_BITS-1:0] dac_code,
  output logic [2:0]          header_status,
  output logic [31:0]         sample_rate,
  output logic [15:0]         channel_count,
  output logic [15:0]         sample_bits,
  output logic [31:0]         data_length,
  input  logic                cfg_write,
  input  logic [7:0]          volume_divisor
);

  logic     in_fire;
  logic     job_valid;
  wsd_cmd_t job;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  wsd_cmd_t q_job;

  assign full    = q_full;
  assign in_fire = push & ~q_full;

  wsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .data_byte  (data_byte),
    .file_start (file_start),
    .job_valid  (job_valid),
    .job        (job)
  );

  wsd_jobq u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr      (in_fire & job_valid),
    .wr_job  (job),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_job  (q_job),
    .q_empty (q_empty)
  );

  wsd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .volume_divisor (volume_divisor),
    .q_empty        (q_empty),
    .q_job          (q_job),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .result_kind    (result_kind),
    .dac_code       (dac_code),
    .header_status  (header_status),
    .sample_rate    (sample_rate),
    .channel_count  (channel_count),
    .sample_bits    (sample_bits),
    .data_length    (data_length)
  );

endmodule
